>>> sv/pcode_stack_machine_step_defines.svh
//------------------------------------------------------------------------------
// pcode_stack_machine_step_defines
// assertion macros for the p-code stack machine
//------------------------------------------------------------------------------
`ifndef PCODE_STACK_MACHINE_STEP_DEFINES_SVH
`define PCODE_STACK_MACHINE_STEP_DEFINES_SVH
// property that must hold whenever reset is released
`define PSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define PSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/psm_pkg.sv
//------------------------------------------------------------------------------
// psm_pkg
// constants and codes shared by the p-code stack machine
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package psm_pkg;
    localparam int MEM_WORDS_DEF = 512;
    localparam int MAX_LEVEL_DEF = 7;
    localparam int WORD_BITS_DEF = 32;
    localparam int ADDR_IN_BITS  = 9;
    localparam int REG_OUT_BITS  = 10;
    localparam int IO_BITS       = 32;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_INSTR = 2'd2;
    localparam logic [1:0] ERR_ADDR  = 2'd3;

    // opcodes
    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_SYS = 4'd9;

    // opr sub-codes
    localparam logic [3:0] OPR_RTN = 4'd0;
    localparam logic [3:0] OPR_ADD = 4'd1;
    localparam logic [3:0] OPR_SUB = 4'd2;
    localparam logic [3:0] OPR_MUL = 4'd3;
    localparam logic [3:0] OPR_DIV = 4'd4;
    localparam logic [3:0] OPR_EQL = 4'd5;
    localparam logic [3:0] OPR_NEQ = 4'd6;
    localparam logic [3:0] OPR_LSS = 4'd7;
    localparam logic [3:0] OPR_LEQ = 4'd8;
    localparam logic [3:0] OPR_GTR = 4'd9;
    localparam logic [3:0] OPR_GEQ = 4'd10;

    // sys sub-codes
    localparam logic [1:0] SYS_OUT  = 2'd1;
    localparam logic [1:0] SYS_IN   = 2'd2;
    localparam logic [1:0] SYS_HALT = 2'd3;

    // beat kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EXEC = 1'b1;
endpackage

>>> sv/pcode_stack_machine_step.sv
// Executes one PL/0 p-code instruction, or loads one memory word, per input beat.
// A load, a fetch past the end of memory and any beat after halt go from the idle state
// straight to the result beat. An instruction is fetched and decoded and then faults at
// decode or runs on (JMP, INC and halt end soonest, CAL latest short of DIV), walks one
// link per static-link level followed and runs the divider for DIV: three fetch reads, up
// to two operand reads and up to three writes go one at a time through the state memory,
// and the divider retires one quotient bit per cycle. tready rises again in the cycle
// after the result beat is accepted. After reset the memory is cleared in the clear
// state, during which no beat is accepted.
//------------------------------------------------------------------------------
// pcode_stack_machine_step
// memory-centered sequencer for the PL/0 p-code stack machine
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcode_stack_machine_step_defines.svh"
module pcode_stack_machine_step #(
    parameter int MEM_WORDS = psm_pkg::MEM_WORDS_DEF,
    parameter int MAX_LEVEL = psm_pkg::MAX_LEVEL_DEF,
    parameter int WORD_BITS = psm_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // load_addr[8:0], load_word[40:9], in_value[72:41], zero pad
    input  logic [79:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc[9:0], bp[19:10], sp[29:20], out_value[61:30], error[63:62]
    output logic [63:0] m_axis_tdata,
    // out_valid[0], halted[1]
    output logic [1:0]  m_axis_tuser
);
    import psm_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = AW + 2;           // holds MEM_WORDS and a sign margin
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int LW = $clog2(MAX_LEVEL + 1);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_F0   = 4'd2;
    localparam logic [3:0] S_F1   = 4'd3;
    localparam logic [3:0] S_F2   = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_RD1  = 4'd7;
    localparam logic [3:0] S_RD2  = 4'd8;
    localparam logic [3:0] S_EXE  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_WR   = 4'd11;
    localparam logic [3:0] S_CAL2 = 4'd12;
    localparam logic [3:0] S_CAL3 = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // state memory with registered read
    word_t            mem [MEM_WORDS];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    word_t            mem_wdata;
    word_t            mem_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [RW-1:0]    pc_reg, pc_next, bp_reg, bp_next, sp_reg, sp_next;
    logic             halt_reg, halt_next;
    word_t            op_reg, op_next, lv_reg, lv_next, m_reg, m_next;
    word_t            x_reg, x_next, y_reg, y_next, inval_reg, inval_next;
    logic [RW-1:0]    b_reg, b_next;
    logic [LW-1:0]    lcnt_reg, lcnt_next;
    // divider
    logic [WORD_BITS-1:0] q_reg, q_next, rem_reg, rem_next, dvs_reg, dvs_next;
    logic [CW-1:0]    dcnt_reg, dcnt_next;
    logic             qneg_reg, qneg_next;
    // output holding
    logic             ovalid_reg, ovalid_next, ook_reg, ook_next;
    logic [31:0]      oval_reg, oval_next;
    logic [1:0]       err_reg, err_next;
    logic [RW-1:0]    wa_reg, wa_next;
    word_t            wd_reg, wd_next;

    logic in_fire;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    logic [AW-1:0] ld_addr;
    word_t         ld_word, in_word;
    assign ld_addr = AW'(s_axis_tdata[8:0]);
    assign ld_word = WORD_BITS'(signed'(s_axis_tdata[40:9]));
    assign in_word = WORD_BITS'(signed'(s_axis_tdata[72:41]));

    localparam logic [RW-1:0] MEMW = RW'(MEM_WORDS);

    // small helpers on signed words
    function automatic logic in_range(input word_t v, input logic incl_top);
        logic ok;
        begin
            ok = !v[WORD_BITS-1] && (incl_top ? (v <= word_t'(MEM_WORDS))
                                              : (v < word_t'(MEM_WORDS)));
            return ok;
        end
    endfunction

    word_t         b_w, sp_w, addr_w, alu_r, sum_r, diff_r, prod_r;
    logic          addr_ok;
    logic [RW-1:0] inc_sp;
    word_t         newsp_w;
    assign b_w    = word_t'(b_reg);
    assign sp_w   = word_t'(sp_reg);
    assign addr_w = b_w - m_reg;
    assign addr_ok = !addr_w[WORD_BITS-1] && (addr_w < word_t'(MEM_WORDS))
                     && (m_reg <= b_w);
    assign newsp_w = sp_w - m_reg;
    assign inc_sp  = RW'(newsp_w);
    assign sum_r  = x_reg + y_reg;
    assign diff_r = x_reg - y_reg;
    assign prod_r = x_reg * y_reg;

    // divider step: restoring, one bit per cycle
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS-1:0] rem_sh;
    assign rem_sh = {rem_reg[WORD_BITS-2:0], q_reg[WORD_BITS-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        pc_next = pc_reg; bp_next = bp_reg; sp_next = sp_reg; halt_next = halt_reg;
        op_next = op_reg; lv_next = lv_reg; m_next = m_reg;
        x_next = x_reg; y_next = y_reg; inval_next = inval_reg;
        b_next = b_reg; lcnt_next = lcnt_reg;
        q_next = q_reg; rem_next = rem_reg; dvs_next = dvs_reg;
        dcnt_next = dcnt_reg; qneg_next = qneg_reg;
        ovalid_next = ovalid_reg; ook_next = ook_reg; oval_next = oval_reg;
        err_next = err_reg; wa_next = wa_reg; wd_next = wd_reg;
        mem_we = 1'b0; mem_waddr = AW'(wa_reg); mem_wdata = wd_reg;
        mem_raddr = AW'(pc_reg);
        alu_r = '0;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1; mem_waddr = clr_reg; mem_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    err_next = ERR_NONE; ook_next = 1'b0; oval_next = '0;
                    inval_next = in_word;
                    if (halt_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser == FUNC_LOAD)
                    begin
                        if ({1'b0, s_axis_tdata[8:0]} < 10'(MEM_WORDS))
                        begin
                            mem_we = 1'b1; mem_waddr = ld_addr; mem_wdata = ld_word;
                        end
                        else
                        begin
                            err_next = ERR_ADDR;
                        end
                        state_next = S_OUT;
                    end
                    else if (pc_reg + RW'(2) >= MEMW)
                    begin
                        err_next = ERR_ADDR;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mem_raddr = AW'(pc_reg);
                        state_next = S_F0;
                    end
                end
            end
            S_F0:
            begin
                op_next = mem_q;
                mem_raddr = AW'(pc_reg + RW'(1));
                state_next = S_F1;
            end
            S_F1:
            begin
                lv_next = mem_q;
                mem_raddr = AW'(pc_reg + RW'(2));
                state_next = S_F2;
            end
            S_F2:
            begin
                m_next = mem_q;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                pc_next = pc_reg + RW'(3);
                b_next = bp_reg;
                lcnt_next = '0;
                if ((op_reg == word_t'(OP_LOD) || op_reg == word_t'(OP_STO)
                     || op_reg == word_t'(OP_CAL))
                    && (lv_reg[WORD_BITS-1] || lv_reg > word_t'(MAX_LEVEL)))
                begin
                    err_next = ERR_INSTR;
                    state_next = S_OUT;
                end
                else if (op_reg == word_t'(OP_LOD) || op_reg == word_t'(OP_STO)
                         || op_reg == word_t'(OP_CAL))
                begin
                    if (lv_reg == '0)
                    begin
                        state_next = S_RD1;
                    end
                    else
                    begin
                        mem_raddr = AW'(bp_reg);
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    state_next = S_RD1;
                end
            end
            S_WALK:
            begin
                // mem_q holds the link read at b_reg
                if (!in_range(mem_q, 1'b0))
                begin
                    err_next = ERR_ADDR;
                    state_next = S_OUT;
                end
                else
                begin
                    b_next = RW'(mem_q);
                    lcnt_next = lcnt_reg + 1'b1;
                    if (word_t'(lcnt_reg + 1'b1) == lv_reg)
                    begin
                        state_next = S_RD1;
                    end
                    else
                    begin
                        mem_raddr = AW'(mem_q);
                    end
                end
            end
            S_RD1:
            begin
                // validate and issue the first operand read; INC, JMP and halt finish here
                state_next = S_RD2;
                case (op_reg[3:0] & {4{op_reg[WORD_BITS-1:4] == '0}})
                    OP_LIT:
                    begin
                        if (sp_reg < RW'(1)) begin err_next = ERR_ADDR; state_next = S_OUT; end
                    end
                    OP_OPR:
                    begin
                        if (m_reg == '0)
                        begin
                            if (bp_reg < RW'(2) || bp_reg + RW'(1) > MEMW)
                            begin
                                err_next = ERR_ADDR; state_next = S_OUT;
                            end
                            else
                            begin
                                mem_raddr = AW'(bp_reg - RW'(1));
                            end
                        end
                        else if (!m_reg[WORD_BITS-1] && m_reg <= word_t'(OPR_GEQ))
                        begin
                            if (sp_reg + RW'(1) >= MEMW)
                            begin
                                err_next = ERR_ADDR; state_next = S_OUT;
                            end
                            else
                            begin
                                mem_raddr = AW'(sp_reg + RW'(1));
                            end
                        end
                        else
                        begin
                            err_next = ERR_INSTR; state_next = S_OUT;
                        end
                    end
                    OP_LOD:
                    begin
                        if (!addr_ok || sp_reg < RW'(1))
                        begin
                            err_next = ERR_ADDR; state_next = S_OUT;
                        end
                        else
                        begin
                            mem_raddr = AW'(addr_w);
                        end
                    end
                    OP_STO:
                    begin
                        if (!addr_ok || sp_reg >= MEMW)
                        begin
                            err_next = ERR_ADDR; state_next = S_OUT;
                        end
                        else
                        begin
                            mem_raddr = AW'(sp_reg);
                        end
                    end
                    OP_CAL:
                    begin
                        if (sp_reg < RW'(3) || !in_range(m_reg, 1'b1))
                        begin
                            err_next = ERR_ADDR; state_next = S_OUT;
                        end
                    end
                    OP_INC:
                    begin
                        if (m_reg > sp_w || m_reg < sp_w - word_t'(MEM_WORDS))
                        begin
                            err_next = ERR_ADDR;
                        end
                        else
                        begin
                            sp_next = inc_sp;
                        end
                        state_next = S_OUT;
                    end
                    OP_JMP:
                    begin
                        if (!in_range(m_reg, 1'b1)) err_next = ERR_ADDR;
                        else pc_next = RW'(m_reg);
                        state_next = S_OUT;
                    end
                    OP_JPC:
                    begin
                        if (sp_reg >= MEMW) begin err_next = ERR_ADDR; state_next = S_OUT; end
                        else mem_raddr = AW'(sp_reg);
                    end
                    OP_SYS:
                    begin
                        if (m_reg == word_t'(SYS_OUT))
                        begin
                            if (sp_reg >= MEMW) begin err_next = ERR_ADDR; state_next = S_OUT; end
                            else mem_raddr = AW'(sp_reg);
                        end
                        else if (m_reg == word_t'(SYS_IN))
                        begin
                            if (sp_reg < RW'(1)) begin err_next = ERR_ADDR; state_next = S_OUT; end
                        end
                        else if (m_reg == word_t'(SYS_HALT))
                        begin
                            halt_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            err_next = ERR_INSTR; state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        err_next = ERR_INSTR;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RD2:
            begin
                // first operand arrives; issue the second read where needed
                x_next = mem_q;
                state_next = S_EXE;
                if (op_reg == word_t'(OP_OPR))
                begin
                    mem_raddr = (m_reg == '0) ? AW'(bp_reg - RW'(2)) : AW'(sp_reg);
                end
            end
            S_EXE:
            begin
                y_next = mem_q;
                state_next = S_WR;
                case (op_reg[3:0])
                    OP_LIT:
                    begin
                        wa_next = sp_reg - RW'(1); wd_next = m_reg; sp_next = sp_reg - RW'(1);
                    end
                    OP_OPR:
                    begin
                        if (m_reg == '0)
                        begin
                            // x = old bp link, mem_q = return pc
                            if (!in_range(x_reg, 1'b0) || !in_range(mem_q, 1'b1))
                            begin
                                err_next = ERR_ADDR;
                            end
                            else
                            begin
                                sp_next = bp_reg + RW'(1);
                                bp_next = RW'(x_reg);
                                pc_next = RW'(mem_q);
                            end
                            state_next = S_OUT;
                        end
                        else if (m_reg == word_t'(OPR_DIV))
                        begin
                            if (mem_q == '0)
                            begin
                                err_next = ERR_DIV0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                qneg_next = x_reg[WORD_BITS-1] ^ mem_q[WORD_BITS-1];
                                q_next = x_reg[WORD_BITS-1] ? -x_reg : x_reg;
                                dvs_next = mem_q[WORD_BITS-1] ? -mem_q : mem_q;
                                rem_next = '0;
                                dcnt_next = '0;
                                state_next = S_DIV;
                            end
                        end
                        else
                        begin
                            state_next = S_DIV;
                            dcnt_next = CW'(WORD_BITS);
                        end
                    end
                    OP_LOD:
                    begin
                        wa_next = sp_reg - RW'(1); wd_next = x_reg; sp_next = sp_reg - RW'(1);
                    end
                    OP_STO:
                    begin
                        wa_next = RW'(addr_w); wd_next = x_reg; sp_next = sp_reg + RW'(1);
                    end
                    OP_CAL:
                    begin
                        wa_next = sp_reg - RW'(1); wd_next = word_t'(b_reg);
                        state_next = S_CAL2;
                    end
                    OP_JPC:
                    begin
                        if (x_reg == '0 && !in_range(m_reg, 1'b1))
                        begin
                            err_next = ERR_ADDR;
                        end
                        else
                        begin
                            if (x_reg == '0) pc_next = RW'(m_reg);
                            sp_next = sp_reg + RW'(1);
                        end
                        state_next = S_OUT;
                    end
                    OP_SYS:
                    begin
                        if (m_reg == word_t'(SYS_OUT))
                        begin
                            ook_next = 1'b1; oval_next = 32'(x_reg);
                            sp_next = sp_reg + RW'(1);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            wa_next = sp_reg - RW'(1); wd_next = inval_reg;
                            sp_next = sp_reg - RW'(1);
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV:
            begin
                // y_reg holds the second operand
                if (m_reg != word_t'(OPR_DIV))
                begin
                    case (m_reg[3:0])
                        OPR_ADD: alu_r = sum_r;
                        OPR_SUB: alu_r = diff_r;
                        OPR_MUL: alu_r = prod_r;
                        OPR_EQL: alu_r = word_t'(x_reg == y_reg);
                        OPR_NEQ: alu_r = word_t'(x_reg != y_reg);
                        OPR_LSS: alu_r = word_t'(x_reg < y_reg);
                        OPR_LEQ: alu_r = word_t'(x_reg <= y_reg);
                        OPR_GTR: alu_r = word_t'(x_reg > y_reg);
                        default: alu_r = word_t'(x_reg >= y_reg);
                    endcase
                    wa_next = sp_reg + RW'(1); wd_next = alu_r;
                    sp_next = sp_reg + RW'(1);
                    state_next = S_WR;
                end
                else if (dcnt_reg == CW'(WORD_BITS))
                begin
                    wa_next = sp_reg + RW'(1);
                    wd_next = qneg_reg ? -word_t'(q_reg) : word_t'(q_reg);
                    sp_next = sp_reg + RW'(1);
                    state_next = S_WR;
                end
                else
                begin
                    if (!trial[WORD_BITS])
                    begin
                        rem_next = trial[WORD_BITS-1:0];
                        q_next = {q_reg[WORD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next = {q_reg[WORD_BITS-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_CAL2:
            begin
                mem_we = 1'b1;
                wa_next = sp_reg - RW'(2); wd_next = word_t'(bp_reg);
                state_next = S_CAL3;
            end
            S_CAL3:
            begin
                mem_we = 1'b1;
                wa_next = sp_reg - RW'(3); wd_next = word_t'(pc_reg);
                bp_next = sp_reg - RW'(1);
                pc_next = RW'(m_reg);
                state_next = S_WR;
            end
            S_WR:
            begin
                mem_we = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            pc_reg <= '0;
            bp_reg <= RW'(MEM_WORDS - 1);
            sp_reg <= MEMW;
            halt_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= pc_next;
            bp_reg <= bp_next;
            sp_reg <= sp_next;
            halt_reg <= halt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; lv_reg <= lv_next; m_reg <= m_next;
        x_reg <= x_next; y_reg <= y_next; inval_reg <= inval_next;
        b_reg <= b_next; lcnt_reg <= lcnt_next;
        q_reg <= q_next; rem_reg <= rem_next; dvs_reg <= dvs_next;
        dcnt_reg <= dcnt_next; qneg_reg <= qneg_next;
        ook_reg <= ook_next; oval_reg <= oval_next; err_reg <= err_next;
        wa_reg <= wa_next; wd_reg <= wd_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {err_reg, oval_reg, 10'(sp_reg), 10'(bp_reg), 10'(pc_reg)};
    assign m_axis_tuser = {halt_reg, ook_reg};

    `PSM_ASSERT(a_ready_idle, !s_axis_tready || state_reg == S_IDLE, "ready outside idle")
    `PSM_ASSERT_NEXT(a_halt_sticks, halt_reg, halt_reg, "halt flag dropped")
    `PSM_ASSERT(a_sp_range, sp_reg <= MEMW, "stack pointer out of range")
    `PSM_ASSERT_NEXT(a_no_accept_busy, in_fire, !s_axis_tready, "accept while busy")
endmodule

>>> dv/tb_pcode_stack_machine_step.sv
//------------------------------------------------------------------------------
// tb_pcode_stack_machine_step
// self-checking testbench for the p-code stack machine: loads instructions and
// runs them one beat at a time, predicts every result beat with a behavioral
// model of the machine and compares it field by field under random flow control
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_pcode_stack_machine_step;
    import psm_pkg::*;

    localparam int MEMW       = MEM_WORDS_DEF;
    localparam int PC_GUARD   = 480;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [31:0] mem [MEMW];
        logic [9:0]  pc;
        logic [9:0]  bp;
        logic [9:0]  sp;
        bit          halt;
    } machine_t;

    typedef struct {
        bit          func;
        logic [8:0]  addr;
        logic [31:0] word;
        logic [31:0] inval;
        int          send_idle;
        int          recv_idle;
        bit          drain;
        bit          hold;
    } beat_t;

    typedef struct {
        logic [9:0]  pc;
        logic [9:0]  bp;
        logic [9:0]  sp;
        bit          out_valid;
        logic [31:0] out_value;
        bit          halted;
        logic [1:0]  error;
    } step_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    machine_t  gen_st;
    machine_t  chk_st;
    beat_t     pend_q[$];
    step_out_t expected_q[$];
    beat_t     cur_beat;
    int        recv_idle_pct = 0;
    bit        hold_go = 0;
    bit        hold_done = 0;
    int        hold_cnt = 0;
    int        errors = 0;
    int        cycles = 0;

    // emission settings for the next items queued
    int g_send = 0;
    int g_recv = 0;
    bit g_drain = 0;
    bit g_hold = 0;

    pcode_stack_machine_step dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // load_addr[8:0], load_word[40:9], in_value[72:41], zero pad
        .s_axis_tdata  (s_axis_tdata),
        // func
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // pc[9:0], bp[19:10], sp[29:20], out_value[61:30], error[63:62]
        .m_axis_tdata  (m_axis_tdata),
        // out_valid[0], halted[1]
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_machine(ref machine_t st);
        for (int i = 0; i < MEMW; i++)
            st.mem[i] = '0;
        st.pc   = 10'd0;
        st.bp   = 10'(MEMW - 1);
        st.sp   = 10'(MEMW);
        st.halt = 0;
    endfunction

    function automatic longint sword(logic [31:0] w);
        return longint'($signed(w));
    endfunction

    // follow static links; 0 when a link leaves memory
    function automatic bit frame_base(ref machine_t st, input int bp, input longint lv,
                                      output int b);
        longint v;
        b = bp;
        for (longint i = 0; i < lv; i++)
        begin
            v = sword(st.mem[b]);
            if (v < 0 || v >= MEMW)
                return 0;
            b = int'(v);
        end
        return 1;
    endfunction

    function automatic bit frame_addr(int b, longint m, output int a);
        a = 0;
        if (m > b || m <= b - MEMW)
            return 0;
        a = int'(b - m);
        return 1;
    endfunction

    function automatic bit target_in_range(longint m);
        return m >= 0 && m <= MEMW;
    endfunction

    // one executed instruction; returns the error code
    function automatic logic [1:0] run_instr(ref machine_t st, input logic [31:0] inval,
                                             output bit ov, output logic [31:0] oval);
        int          pc, bp, sp, b, a;
        longint      op, lv, m, x, y, nb, np;
        logic [31:0] r;
        ov   = 0;
        oval = '0;
        pc   = st.pc;
        bp   = st.bp;
        sp   = st.sp;
        if (pc + 2 >= MEMW)
            return ERR_ADDR;
        op = sword(st.mem[pc]);
        lv = sword(st.mem[pc + 1]);
        m  = sword(st.mem[pc + 2]);
        pc += 3;
        st.pc = 10'(pc);
        if ((op == OP_LOD || op == OP_STO || op == OP_CAL) && (lv < 0 || lv > MAX_LEVEL_DEF))
            return ERR_INSTR;
        case (op)
            OP_LIT:
            begin
                if (sp < 1) return ERR_ADDR;
                st.mem[sp - 1] = m[31:0];
                st.sp = 10'(sp - 1);
            end
            OP_OPR:
            begin
                if (m == OPR_RTN)
                begin
                    if (bp < 2 || bp + 1 > MEMW) return ERR_ADDR;
                    nb = sword(st.mem[bp - 1]);
                    np = sword(st.mem[bp - 2]);
                    if (nb < 0 || nb >= MEMW || !target_in_range(np)) return ERR_ADDR;
                    st.sp = 10'(bp + 1);
                    st.bp = 10'(nb);
                    st.pc = 10'(np);
                end
                else if (m >= OPR_ADD && m <= OPR_GEQ)
                begin
                    if (sp + 1 >= MEMW) return ERR_ADDR;
                    x = sword(st.mem[sp + 1]);
                    y = sword(st.mem[sp]);
                    case (m)
                        OPR_ADD: r = st.mem[sp + 1] + st.mem[sp];
                        OPR_SUB: r = st.mem[sp + 1] - st.mem[sp];
                        OPR_MUL: r = st.mem[sp + 1] * st.mem[sp];
                        OPR_DIV:
                        begin
                            if (y == 0) return ERR_DIV0;
                            if (y == -1) r = 32'd0 - st.mem[sp + 1];
                            else r = 32'(x / y);
                        end
                        OPR_EQL: r = {31'd0, x == y};
                        OPR_NEQ: r = {31'd0, x != y};
                        OPR_LSS: r = {31'd0, x < y};
                        OPR_LEQ: r = {31'd0, x <= y};
                        OPR_GTR: r = {31'd0, x > y};
                        default: r = {31'd0, x >= y};
                    endcase
                    st.mem[sp + 1] = r;
                    st.sp = 10'(sp + 1);
                end
                else
                    return ERR_INSTR;
            end
            OP_LOD:
            begin
                if (!frame_base(st, bp, lv, b) || !frame_addr(b, m, a) || sp < 1)
                    return ERR_ADDR;
                st.mem[sp - 1] = st.mem[a];
                st.sp = 10'(sp - 1);
            end
            OP_STO:
            begin
                if (!frame_base(st, bp, lv, b) || !frame_addr(b, m, a) || sp >= MEMW)
                    return ERR_ADDR;
                st.mem[a] = st.mem[sp];
                st.sp = 10'(sp + 1);
            end
            OP_CAL:
            begin
                if (!frame_base(st, bp, lv, b) || sp < 3 || !target_in_range(m))
                    return ERR_ADDR;
                st.mem[sp - 1] = 32'(b);
                st.mem[sp - 2] = 32'(bp);
                st.mem[sp - 3] = 32'(pc);
                st.bp = 10'(sp - 1);
                st.pc = 10'(m);
            end
            OP_INC:
            begin
                if (m > sp || m < sp - MEMW) return ERR_ADDR;
                st.sp = 10'(sp - m);
            end
            OP_JMP:
            begin
                if (!target_in_range(m)) return ERR_ADDR;
                st.pc = 10'(m);
            end
            OP_JPC:
            begin
                if (sp >= MEMW) return ERR_ADDR;
                if (st.mem[sp] == 0)
                begin
                    if (!target_in_range(m)) return ERR_ADDR;
                    st.pc = 10'(m);
                end
                st.sp = 10'(sp + 1);
            end
            OP_SYS:
            begin
                if (m == SYS_OUT)
                begin
                    if (sp >= MEMW) return ERR_ADDR;
                    ov    = 1;
                    oval  = st.mem[sp];
                    st.sp = 10'(sp + 1);
                end
                else if (m == SYS_IN)
                begin
                    if (sp < 1) return ERR_ADDR;
                    st.mem[sp - 1] = inval;
                    st.sp = 10'(sp - 1);
                end
                else if (m == SYS_HALT)
                    st.halt = 1;
                else
                    return ERR_INSTR;
            end
            default: return ERR_INSTR;
        endcase
        return ERR_NONE;
    endfunction

    // one beat through the machine
    function automatic step_out_t machine_step(ref machine_t st, input beat_t it);
        step_out_t o;
        o.out_valid = 0;
        o.out_value = '0;
        o.error     = ERR_NONE;
        if (!st.halt)
        begin
            if (it.func == FUNC_LOAD)
                st.mem[it.addr] = it.word;
            else
                o.error = run_instr(st, it.inval, o.out_valid, o.out_value);
        end
        o.pc     = st.pc;
        o.bp     = st.bp;
        o.sp     = st.sp;
        o.halted = st.halt;
        return o;
    endfunction

    function automatic beat_t make_beat(bit func, logic [8:0] addr, logic [31:0] word,
                                        logic [31:0] inval);
        beat_t it;
        it.func      = func;
        it.addr      = addr;
        it.word      = word;
        it.inval     = inval;
        it.send_idle = g_send;
        it.recv_idle = g_recv;
        it.drain     = 0;
        it.hold      = 0;
        return it;
    endfunction

    function automatic void queue_beat(beat_t it);
        step_out_t o;
        it.drain = g_drain;
        it.hold  = g_hold;
        g_drain  = 0;
        g_hold   = 0;
        pend_q.push_back(it);
        o = machine_step(gen_st, it);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // load an instruction at pc (optionally) and run it; steer pc back if it runs off
    function automatic void issue_instr(logic [31:0] op, logic [31:0] lv, logic [31:0] m,
                                        logic [31:0] inval, bit with_load);
        machine_t  trial;
        step_out_t o;
        beat_t     seq[4];
        int        n;
        for (int pass = 0; pass < 2; pass++)
        begin
            n = 0;
            if (with_load)
            begin
                seq[0] = make_beat(FUNC_LOAD, gen_st.pc[8:0], op, $urandom);
                seq[1] = make_beat(FUNC_LOAD, gen_st.pc[8:0] + 9'd1, lv, $urandom);
                seq[2] = make_beat(FUNC_LOAD, gen_st.pc[8:0] + 9'd2, m, $urandom);
                n = 3;
            end
            seq[n] = make_beat(FUNC_EXEC, 9'($urandom), $urandom, inval);
            n++;
            trial = gen_st;
            for (int i = 0; i < n; i++)
                o = machine_step(trial, seq[i]);
            if (trial.halt || trial.pc <= PC_GUARD || pass == 1)
                break;
            op = 32'(OP_JMP);
            lv = 0;
            m = $urandom_range(0, 200);
            with_load = 1;
        end
        for (int i = 0; i < n; i++)
            queue_beat(seq[i]);
    endfunction

    function automatic void issue_random();
        logic [31:0] op, lv, m, inval;
        int k;
        k     = $urandom_range(0, 23);
        lv    = 32'($urandom_range(0, 2));
        inval = pick_word();
        if ($urandom_range(0, 9) == 0)
            lv = ($urandom_range(0, 1) == 0) ? 32'd8 : 32'hFFFF_FFFF;
        if (k < 3)
        begin
            op = 32'(OP_LIT);
            m  = pick_word();
        end
        else if (k < 8)
        begin
            op = 32'(OP_OPR);
            m  = ($urandom_range(0, 9) == 0) ? pick_word() : 32'($urandom_range(0, 10));
        end
        else if (k < 10)
        begin
            op = 32'(OP_LOD);
            m  = 32'($urandom_range(0, 9)) - 32'd2;
        end
        else if (k < 12)
        begin
            op = 32'(OP_STO);
            m  = 32'($urandom_range(0, 9)) - 32'd2;
        end
        else if (k < 13)
        begin
            op = 32'(OP_CAL);
            m  = 32'($urandom_range(0, 300));
        end
        else if (k < 15)
        begin
            op = 32'(OP_INC);
            m  = ($urandom_range(0, 9) == 0) ? pick_word() : 32'($urandom_range(0, 8)) - 32'd4;
        end
        else if (k < 17)
        begin
            op = ($urandom_range(0, 1) == 0) ? 32'(OP_JMP) : 32'(OP_JPC);
            m  = ($urandom_range(0, 7) == 0) ? pick_word() : 32'($urandom_range(0, 300));
        end
        else if (k < 22)
        begin
            op = 32'(OP_SYS);
            case ($urandom_range(0, 9))
                0: m = 32'd0;
                1: m = 32'd7;
                2, 3, 4, 5: m = 32'(SYS_OUT);
                default: m = 32'(SYS_IN);
            endcase
        end
        else
        begin
            op = ($urandom_range(0, 1) == 0) ? 32'd0 : pick_word();
            if (op >= OP_LIT && op <= OP_SYS)
                op = 32'd10;
            m = pick_word();
        end
        if ($urandom_range(0, 9) == 0)
            queue_beat(make_beat(FUNC_LOAD, 9'($urandom), pick_word(), $urandom));
        else
            issue_instr(op, lv, m, inval, $urandom_range(0, 4) != 0);
    endfunction

    // stimulus and end of run
    initial
    begin
        clear_machine(gen_st);
        clear_machine(chk_st);

        // directed: wrapping divide, output, divide by zero, bad opcode
        g_send = 29;
        g_recv = 53;
        issue_instr(32'(OP_LIT), 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        issue_instr(32'(OP_LIT), 0, 32'hFFFF_FFFF, 32'h8000_0000, 1);
        issue_instr(32'(OP_OPR), 0, 32'(OPR_DIV), 0, 1);
        issue_instr(32'(OP_SYS), 0, 32'(SYS_OUT), 0, 1);
        issue_instr(32'(OP_LIT), 0, 32'd0, 0, 1);
        issue_instr(32'(OP_OPR), 0, 32'(OPR_DIV), 0, 1);
        issue_instr(32'd0, 0, 0, 32'hFFFF_FFFF, 1);

        // random phases: receiver idle, sender idle, then full rate
        while (pend_q.size() < 280)
        begin
            if (pend_q.size() >= 120 && !hold_done && pend_q.size() < 124)
                g_hold = 1;
            issue_random();
        end
        g_send = 53;
        g_recv = 29;
        while (pend_q.size() < 500)
            issue_random();
        g_send  = 0;
        g_recv  = 0;
        g_drain = 1;
        while (pend_q.size() < 640)
            issue_random();

        // halt, then beats that must change nothing
        issue_instr(32'(OP_SYS), 0, 32'(SYS_HALT), 0, 1);
        queue_beat(make_beat(FUNC_LOAD, 9'd5, 32'h1234_5678, 0));
        queue_beat(make_beat(FUNC_EXEC, 9'd0, 0, 32'hFFFF_FFFF));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("tb_pcode_stack_machine_step: done, clean");
        else
            $display("tb_pcode_stack_machine_step: done, errors");
        $finish;
    end

    // driver: predict on each accepted beat, then offer the next one
    always @(posedge clk)
    begin
        beat_t     nxt;
        step_out_t o;
        bit        give;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                o = machine_step(chk_st, cur_beat);
                expected_q.push_back(o);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                give = 0;
                if (pend_q.size() != 0 && !(pend_q[0].drain && expected_q.size() != 0))
                    give = $urandom_range(0, 99) >= pend_q[0].send_idle;
                if (give)
                begin
                    nxt = pend_q.pop_front();
                    cur_beat = nxt;
                    recv_idle_pct = nxt.recv_idle;
                    if (nxt.hold)
                        hold_go = 1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, nxt.inval, nxt.word, nxt.addr};
                    s_axis_tuser  <= nxt.func;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        step_out_t e;
        logic [9:0]  a_pc, a_bp, a_sp;
        logic [31:0] a_val;
        logic [1:0]  a_err;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                a_pc  = m_axis_tdata[9:0];
                a_bp  = m_axis_tdata[19:10];
                a_sp  = m_axis_tdata[29:20];
                a_val = m_axis_tdata[61:30];
                a_err = m_axis_tdata[63:62];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h/%h",
                             $realtime, m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (a_pc !== e.pc)
                    begin
                        $display("%0t: pc expected %0d actual %0d", $realtime, e.pc, a_pc);
                        errors++;
                    end
                    if (a_bp !== e.bp)
                    begin
                        $display("%0t: bp expected %0d actual %0d", $realtime, e.bp, a_bp);
                        errors++;
                    end
                    if (a_sp !== e.sp)
                    begin
                        $display("%0t: sp expected %0d actual %0d", $realtime, e.sp, a_sp);
                        errors++;
                    end
                    if (a_val !== e.out_value)
                    begin
                        $display("%0t: out_value expected %h actual %h", $realtime,
                                 e.out_value, a_val);
                        errors++;
                    end
                    if (a_err !== e.error)
                    begin
                        $display("%0t: error expected %0d actual %0d", $realtime, e.error,
                                 a_err);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== e.out_valid)
                    begin
                        $display("%0t: out_valid expected %0d actual %0d", $realtime,
                                 e.out_valid, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== e.halted)
                    begin
                        $display("%0t: halted expected %0d actual %0d", $realtime,
                                 e.halted, m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
            // long hold-off once, otherwise random stalls
            if (hold_go && !hold_done)
            begin
                hold_done = 1;
                hold_cnt  = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_pcode_stack_machine_step: done, errors");
            $finish;
        end
    end

endmodule
